FILE: hdl/assert_macros.svh
// assertion macros used by the formatter rtl file
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational condition checked at every rising clock edge outside reset
`define AST_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// same-cycle implication
`define AST_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ipv6fmt_pkg.sv
// types and constants for the ipv6 address text formatter
// no dependencies; imported by ipv6_address_text_formatter_top
`default_nettype none

package ipv6fmt_pkg;

    localparam int GROUP_COUNT = 8;
    localparam int GROUP_W     = 16;
    localparam int NIBBLE_W    = 4;
    localparam int CHAR_W      = 7;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3a;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    typedef logic [2:0] grp_idx_t;
    typedef logic [2:0] pos_t;

    typedef struct packed {
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } out_item_t;

    // lower-case hex digit table
    function automatic logic [CHAR_W-1:0] hex_char(input logic [NIBBLE_W-1:0] nib);
        logic [CHAR_W-1:0] c;
        case (nib)
            4'h0: c = 7'h30;
            4'h1: c = 7'h31;
            4'h2: c = 7'h32;
            4'h3: c = 7'h33;
            4'h4: c = 7'h34;
            4'h5: c = 7'h35;
            4'h6: c = 7'h36;
            4'h7: c = 7'h37;
            4'h8: c = 7'h38;
            4'h9: c = 7'h39;
            4'ha: c = 7'h61;
            4'hb: c = 7'h62;
            4'hc: c = 7'h63;
            4'hd: c = 7'h64;
            4'he: c = 7'h65;
            default: c = 7'h66;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ipv6_address_text_formatter_top.sv
// ipv6 address text formatter top level; uses ipv6fmt_pkg and assert_macros.svh
// path: input holding register, streaming stage, then the result register
// throughput: one character per cycle while m_ready is high; an address gives 2 to 39
//   characters (its text length); the single character output register sets that rate
// reset: aresetn synchronous active low, clears all valid flags and the cursor
`default_nettype none
`include "assert_macros.svh"

module ipv6_address_text_formatter_top
    import ipv6fmt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    // input holding register: takes the next address while the current one streams out
    logic     a_valid_reg, a_valid_next;
    in_item_t a_data_reg;

    // streaming stage: the address being written out plus its compressed-run info
    logic                b_active_reg, b_active_next;
    logic [GROUP_W-1:0]  grp_reg [GROUP_COUNT];
    logic                run_reg;
    grp_idx_t            rs_reg;    // first group of the compressed run
    grp_idx_t            re_reg;    // last zero group of the compressed run
    grp_idx_t            gi_reg, gi_next;
    pos_t                p_reg, p_next;

    // result register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // ------------------------------------------------------------------
    // run detection on the held address (done once, at load)
    // ------------------------------------------------------------------
    logic [GROUP_W-1:0]   a_grp [GROUP_COUNT];
    logic [GROUP_COUNT-1:0] a_zero;
    logic                 run_found;
    logic                 end_found;
    grp_idx_t             run_start;
    grp_idx_t             run_end;

    always_comb begin
        for (int i = 0; i < GROUP_COUNT / 2; i++) begin
            a_grp[i] = a_data_reg.addr_hi[(GROUP_COUNT/2-1-i)*GROUP_W +: GROUP_W];
            a_grp[i + GROUP_COUNT/2] =
                a_data_reg.addr_lo[(GROUP_COUNT/2-1-i)*GROUP_W +: GROUP_W];
        end
        for (int i = 0; i < GROUP_COUNT; i++) begin
            a_zero[i] = (a_grp[i] == '0);
        end
        // first adjacent pair of zero groups opens the run
        run_found = 1'b0;
        run_start = '0;
        for (int i = 0; i < GROUP_COUNT - 1; i++) begin
            if (!run_found && a_zero[i] && a_zero[i+1]) begin
                run_found = 1'b1;
                run_start = grp_idx_t'(i);
            end
        end
        // run ends at the first zero group whose successor is non-zero, or at the end
        end_found = 1'b0;
        run_end   = grp_idx_t'(GROUP_COUNT - 1);
        for (int i = 0; i < GROUP_COUNT - 1; i++) begin
            if (!end_found && (grp_idx_t'(i) >= run_start) && !a_zero[i+1]) begin
                end_found = 1'b1;
                run_end   = grp_idx_t'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // character generation for the cursor (group, position in group)
    // ------------------------------------------------------------------
    logic [GROUP_W-1:0]  cur_grp;
    logic                cur_zero;
    logic                in_run;
    logic                run_to_end;
    pos_t                cur_len;
    logic [NIBBLE_W-1:0] cur_nib;
    logic [CHAR_W-1:0]   cur_char;
    logic                cur_last;
    logic                out_free;
    logic                emit;
    logic                b_load;

    always_comb begin
        cur_grp    = grp_reg[gi_reg];
        cur_zero   = (cur_grp == '0);
        in_run     = run_reg && (gi_reg >= rs_reg) && (gi_reg <= re_reg);
        run_to_end = run_reg && (re_reg == grp_idx_t'(GROUP_COUNT - 1));

        // characters a group writes, its closing colon included
        if (in_run) begin
            if (gi_reg == rs_reg) begin
                cur_len = (rs_reg == '0) ? pos_t'(2) : pos_t'(1);   // "::" at start
            end else begin
                cur_len = pos_t'(1);                                // run reaching the end
            end
        end else if (cur_zero) begin
            cur_len = pos_t'(2);                                    // "0:"
        end else begin
            cur_len = pos_t'(NIBBLE_W + 1);                         // four digits and ":"
        end

        case (p_reg[1:0])
            2'd0:    cur_nib = cur_grp[15:12];
            2'd1:    cur_nib = cur_grp[11:8];
            2'd2:    cur_nib = cur_grp[7:4];
            default: cur_nib = cur_grp[3:0];
        endcase

        if (in_run) begin
            cur_char = CHAR_COLON;
        end else if (cur_zero) begin
            cur_char = (p_reg == '0) ? CHAR_ZERO : CHAR_COLON;
        end else if (p_reg < pos_t'(NIBBLE_W)) begin
            cur_char = hex_char(cur_nib);
        end else begin
            cur_char = CHAR_COLON;
        end

        // last character: before the dropped final colon, or a run's colon at the end
        if (run_to_end) begin
            cur_last = in_run && (gi_reg == rs_reg) && (p_reg == cur_len - pos_t'(1));
        end else begin
            cur_last = (gi_reg == grp_idx_t'(GROUP_COUNT - 1))
                    && (p_reg == cur_len - pos_t'(2));
        end
    end

    // ------------------------------------------------------------------
    // handshake and next-state logic
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = b_active_reg && out_free;
    // streaming stage takes the held address when empty or when its last character leaves
    assign b_load   = a_valid_reg && (!b_active_reg || (emit && cur_last));
    assign s_ready  = !a_valid_reg || b_load;

    always_comb begin
        a_valid_next  = a_valid_reg;
        b_active_next = b_active_reg;
        gi_next       = gi_reg;
        p_next        = p_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (emit) begin
            m_valid_next          = 1'b1;
            m_data_next.text_char = cur_char;
            m_data_next.last_char = cur_last;
            if (cur_last) begin
                b_active_next = 1'b0;
            end else if (p_reg == cur_len - pos_t'(1)) begin
                p_next  = '0;
                // the run start jumps over the rest of the zero run
                gi_next = in_run ? re_reg + grp_idx_t'(1) : gi_reg + grp_idx_t'(1);
            end else begin
                p_next = p_reg + pos_t'(1);
            end
        end

        if (b_load) begin
            b_active_next = 1'b1;
            gi_next       = '0;
            p_next        = '0;
            a_valid_next  = 1'b0;
        end

        if (s_valid && s_ready) begin
            a_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_active_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            gi_reg       <= '0;
            p_reg        <= '0;
        end else begin
            a_valid_reg  <= a_valid_next;
            b_active_reg <= b_active_next;
            m_valid_reg  <= m_valid_next;
            gi_reg       <= gi_next;
            p_reg        <= p_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_data_reg <= s_data;
        end
        if (b_load) begin
            for (int i = 0; i < GROUP_COUNT; i++) begin
                grp_reg[i] <= a_grp[i];
            end
            run_reg <= run_found;
            rs_reg  <= run_start;
            re_reg  <= run_end;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `AST_IMPLY(a_pos_in_group, aclk, aresetn, b_active_reg, p_reg < cur_len,
        "cursor position beyond the text of its group")
    `AST_IMPLY(a_no_skipped_group, aclk, aresetn, b_active_reg && in_run,
        (gi_reg == rs_reg) || (gi_reg == grp_idx_t'(GROUP_COUNT - 1)),
        "cursor stands on a group inside the compressed run")
    `AST_NEXT(a_idle_stage_loads, aclk, aresetn, a_valid_reg && !b_active_reg,
        b_active_reg, "held address not moved into the idle streaming stage")

endmodule

`default_nettype wire

FILE: tb/sv/tb_ipv6_address_text_formatter_top.sv
// testbench for ipv6_address_text_formatter_top: sends 128-bit addresses and checks
// every text character against a behavioral predictor or typed text; needs ipv6fmt_pkg and the rtl
`timescale 1ns / 1ps

module tb_ipv6_address_text_formatter_top;
    import ipv6fmt_pkg::*;

    // ascii codes used by the predictor
    localparam logic [6:0] CH_COLON = 7'h3a;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h61;

    localparam int DIR_N  = 19;    // directed rows
    localparam int RAND_N = 400;   // random addresses after the directed rows
    localparam int SETTLE = 20;    // quiet cycles at the end

    // receiver stall modes
    localparam int RX_FULL     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_HEAVY    = 2;
    localparam int RX_PERIODIC = 3;

    // where the predictor stands relative to the compressed zero run
    typedef enum int {RUN_NONE, RUN_INSIDE, RUN_DONE} run_mode_e;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // characters still owed by the block, oldest first
    out_item_t exp_chars [$];

    int mismatches    = 0;
    int addr_count    = 0;
    int char_count    = 0;
    int text_count    = 0;
    int squeezed_cnt  = 0;   // texts that carried a "::"
    int longest_text  = 0;
    int cur_len       = 0;
    logic cur_squeezed = 1'b0;
    logic prev_colon   = 1'b0;
    int burst_left    = 0;
    int rx_mode       = RX_FULL;
    int rx_left       = 0;
    out_item_t want;

    always #1 aclk = ~aclk;

    ipv6_address_text_formatter_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // hard stop in case the block hangs; far beyond the slowest legal run
    initial begin
        #2000000;
        $display("timeout: %0d characters still expected", exp_chars.size());
        $display("Test completed with failures");
        $finish;
    end

    // builds the expected text of one address and queues it character by character
    function automatic void format_address(input in_item_t a);
        logic [15:0] grp [0:8];
        logic [6:0]  txt [$];
        logic [3:0]  nib;
        run_mode_e   mode;
        out_item_t   c;
        for (int k = 0; k < 8; k++) begin
            if (k < 4) grp[k] = a.addr_hi[63 - 16 * k -: 16];
            else grp[k] = a.addr_lo[63 - 16 * (k - 4) -: 16];
        end
        // the group after the last always counts as non-zero
        grp[8] = 16'h0001;
        mode = RUN_NONE;
        for (int k = 0; k < 8; k++) begin
            if (mode == RUN_INSIDE) begin
                if (grp[k] == 16'h0) begin
                    // run reaching the last group closes the text with "::"
                    if (k == 7) txt.push_back(CH_COLON);
                    continue;
                end
                mode = RUN_DONE;
            end
            if (grp[k] == 16'h0) begin
                if (mode == RUN_NONE && grp[k + 1] == 16'h0) begin
                    // first run of two or more zero groups is squeezed
                    if (k == 0) txt.push_back(CH_COLON);
                    txt.push_back(CH_COLON);
                    mode = RUN_INSIDE;
                end else begin
                    txt.push_back(CH_ZERO);
                    txt.push_back(CH_COLON);
                end
                continue;
            end
            // non-zero group: four digits, leading zeros kept
            for (int d = 3; d >= 0; d--) begin
                nib = grp[k][4 * d +: 4];
                txt.push_back(nib < 4'd10 ? 7'(CH_ZERO + nib) : 7'(CH_A + nib - 4'd10));
            end
            txt.push_back(CH_COLON);
        end
        void'(txt.pop_back());   // no trailing separator
        for (int i = 0; i < txt.size(); i++) begin
            c.text_char = txt[i];
            c.last_char = (i == txt.size() - 1);
            exp_chars.push_back(c);
        end
    endfunction

    task automatic note_mismatch(input string what, input int want_v, input int got_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s, character %0d: expected %02h got %02h",
                     what, char_count, want_v, got_v);
        end
    endtask

    // one input transaction; typed text, when given, replaces the predictor
    task automatic send_address(input in_item_t a, input string typed);
        out_item_t c;
        byte       b;
        s_valid <= 1'b1;
        s_data  <= a;
        do @(posedge aclk); while (!s_ready);
        addr_count++;
        if (typed.len() == 0) begin
            format_address(a);
        end else begin
            for (int i = 0; i < typed.len(); i++) begin
                b = typed[i];
                c.text_char = b[6:0];
                c.last_char = (i == typed.len() - 1);
                exp_chars.push_back(c);
            end
        end
    endtask

    // sender bursts: keep valid high inside a burst, drop it for a random gap after
    task automatic pace_sender();
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 6);
        end else begin
            burst_left--;
        end
    endtask

    // hold the sender until every owed character has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (exp_chars.size() != 0) @(posedge aclk);
    endtask

    // receiver: switches at random between stall patterns
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_FULL, RX_PERIODIC);
            rx_left = $urandom_range(4, 60);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_FULL: begin
                m_ready <= 1'b1;
            end
            RX_COIN: begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end
            RX_HEAVY: begin
                m_ready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_ready <= (rx_left % 5) != 0;
            end
        endcase
    end

    // result monitor: every accepted transaction is matched against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_chars.size() == 0) begin
                note_mismatch("unexpected character", 0, m_data.text_char);
            end else begin
                want = exp_chars.pop_front();
                if (m_data.text_char !== want.text_char)
                    note_mismatch("text_char", want.text_char, m_data.text_char);
                if (m_data.last_char !== want.last_char)
                    note_mismatch("last_char", want.last_char, m_data.last_char);
            end
            // bookkeeping for the summary, taken from what the block produced
            char_count++;
            cur_len++;
            if (prev_colon && m_data.text_char == CH_COLON) cur_squeezed = 1'b1;
            prev_colon = (m_data.text_char == CH_COLON);
            if (m_data.last_char) begin
                text_count++;
                if (cur_squeezed) squeezed_cnt++;
                if (cur_len > longest_text) longest_text = cur_len;
                cur_len      = 0;
                cur_squeezed = 1'b0;
                prev_colon   = 1'b0;
            end
        end
    end

    initial begin
        in_item_t    dir_addr [DIR_N];
        string       dir_text [DIR_N];
        logic [127:0] bits;
        int          shape;
        int          pick;
        int          run_start;
        int          run_len;

        // directed rows; an empty string means the predictor supplies the text
        dir_addr[0]  = {64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000};
        dir_text[0]  = "::";
        dir_addr[1]  = {64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff};
        dir_text[1]  = "ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff";
        dir_addr[2]  = {64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001};
        dir_text[2]  = "::0001";
        dir_addr[3]  = {64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000};
        dir_text[3]  = "0001::";
        dir_addr[4]  = {64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_0000};
        dir_text[4]  = "ffff:ffff:ffff:ffff:ffff:ffff:ffff:0";
        dir_addr[5]  = {64'h0000_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff};
        dir_text[5]  = "0:ffff:ffff:ffff:ffff:ffff:ffff:ffff";
        dir_addr[6]  = {64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210};  // all digits
        dir_text[6]  = "";
        dir_addr[7]  = {64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004};  // two runs
        dir_text[7]  = "";
        dir_addr[8]  = {64'h0001_0000_0002_0000, 64'h0003_0000_0004_0000};  // lone zeros
        dir_text[8]  = "";
        dir_addr[9]  = {64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001};
        dir_text[9]  = "";
        dir_addr[10] = {64'h0001_0000_0000_0002, 64'h0000_0000_0000_0000};  // later run longer
        dir_text[10] = "";
        dir_addr[11] = {64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000};
        dir_text[11] = "";
        dir_addr[12] = {64'h0001_0000_0002_0003, 64'h0004_0005_0000_0000};
        dir_text[12] = "";
        dir_addr[13] = {64'h0000_0000_0000_0000, 64'h0000_0000_0000_ffff};
        dir_text[13] = "";
        dir_addr[14] = {64'h0001_0002_0003_0000, 64'h0000_0006_0007_0008};  // run across halves
        dir_text[14] = "";
        dir_addr[15] = {64'h0000_0000_1000_0100, 64'h0010_0001_0000_0000};  // runs at both ends
        dir_text[15] = "";
        dir_addr[16] = {64'hf00f_0ff0_0000_a5a5, 64'h5a5a_0000_0000_0001};
        dir_text[16] = "";
        dir_addr[17] = {64'h0000_0001_0000_0000, 64'h0000_0000_0000_0000};
        dir_text[17] = "";
        dir_addr[18] = {64'hffff_ffff_ffff_ffff, 64'hffff_ffff_0000_ffff};
        dir_text[18] = "";

        // synchronous reset held at start, then released
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_N; r++) begin
            send_address(dir_addr[r], dir_text[r]);
            if (r == DIR_N - 1) wait_drained();
            else pace_sender();
        end

        // random part: mostly group-structured addresses with many zero groups,
        // forced zero runs at random places, and some fully random patterns
        for (int n = 0; n < RAND_N; n++) begin
            shape = $urandom_range(0, 9);
            for (int k = 0; k < 8; k++) begin
                pick = $urandom_range(0, 9);
                if (shape >= 8) bits[127 - 16 * k -: 16] = 16'($urandom);
                else if (pick < 4) bits[127 - 16 * k -: 16] = 16'h0;
                else if (pick == 4) bits[127 - 16 * k -: 16] = 16'hffff;
                else if (pick == 5) bits[127 - 16 * k -: 16] = 16'h1 << $urandom_range(0, 15);
                else bits[127 - 16 * k -: 16] = 16'($urandom);
            end
            if (shape == 6 || shape == 7) begin
                run_start = $urandom_range(0, 7);
                run_len   = $urandom_range(1, 8 - run_start);
                for (int k = run_start; k < run_start + run_len; k++)
                    bits[127 - 16 * k -: 16] = 16'h0;
            end
            send_address(in_item_t'(bits), "");
            // one full drain in the middle, and at the very end
            if (n == RAND_N / 2 || n == RAND_N - 1) wait_drained();
            else pace_sender();
        end

        repeat (SETTLE) @(posedge aclk);

        if (exp_chars.size() != 0) mismatches++;
        $display("sent %0d addresses, checked %0d characters in %0d texts",
                 addr_count, char_count, text_count);
        $display("%0d texts had a squeezed zero run, longest text %0d characters",
                 squeezed_cnt, longest_text);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
